/* rtl/hsv_to_rgb_converter_top_assert.svh */
// Assertion macros for the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HSVRGB_ASSERT_NOW(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define HSVRGB_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

/* rtl/hsvrgb_pkg.sv */
package hsvrgb_pkg;

    localparam int NUM_STAGES = 5;

    // 255 * 65536: full scale of the q and t numerators
    localparam logic [23:0] FULL_SCALE_FRAC = 24'd16711680;
    localparam logic [16:0] FRAC_ONE        = 17'h10000;
    localparam logic [7:0]  FULL_SCALE      = 8'd255;

    // x / 255 == (x * 0x8081) >> 23, exact for x < 2^16
    localparam logic [15:0] RECIP_255   = 16'h8081;
    localparam int          RECIP_SHIFT = 23;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctl_t;

endpackage

/* rtl/hsvrgb_if.sv */
interface hsvrgb_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue_turn;
    logic [7:0]  sat_level;
    logic [7:0]  val_level;

    modport source (output valid, output hue_turn, output sat_level, output val_level,
                    input ready);
    modport sink   (input valid, input hue_turn, input sat_level, input val_level,
                    output ready);
endinterface

interface hsvrgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* rtl/hsvrgb_pipe_ctrl.sv */
module hsvrgb_pipe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_ready,
    output hsvrgb_pkg::pipe_ctl_t ctl
);

    localparam int N = hsvrgb_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] load;

    // a stage loads when empty or when the stage after it moves
    always_comb
    begin
        load[N-1] = !valid_reg[N-1] || out_ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < N; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl = '{load: load, valid: valid_reg};

endmodule

/* rtl/hsv_to_rgb_converter_top.sv */
// HSV to RGB converter, one pixel per word.
// Input channel hsv: hue_turn (Q0.16 fraction of a turn), sat_level and
// val_level (8-bit, 255 = one). Output channel rgb: red, green, blue, 8 bits.
// Both channels are valid/ready; a word moves when both are high.
// Five register stages: hue sector split, s*f products, v*numerator products,
// reciprocal multiply for the divide by 255, and the sector mux into the
// output register. The multiplies sit in stages 1 to 4; stage 5 is a mux.
// Throughput: one word per cycle, sustained while rgb.ready stays high.
// Each stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles are squeezed out and input is taken while a
// result waits at the output.
// When the receiver stalls, the output holds and words back up stage by
// stage; hsv.ready drops only once all five stages are full. Nothing is
// lost or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline; no clearing pass.
`include "hsv_to_rgb_converter_top_assert.svh"

module hsv_to_rgb_converter_top (
    input  logic         clk,
    input  logic         rst_n,
    hsvrgb_in_if.sink    hsv,
    hsvrgb_out_if.source rgb
);

    hsvrgb_pkg::pipe_ctl_t ctl;

    hsvrgb_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsv.valid),
        .out_ready (rgb.ready),
        .ctl       (ctl)
    );

    assign hsv.ready = ctl.load[0];
    assign rgb.valid = ctl.valid[hsvrgb_pkg::NUM_STAGES-1];

    // stage 1: sector and fraction of hue * 6
    logic [18:0]         h6;
    hsvrgb_pkg::sector_t sector1_reg;
    logic [15:0]         frac1_reg;
    logic [7:0]          sat1_reg;
    logic [7:0]          val1_reg;

    assign h6 = {3'b000, hsv.hue_turn} * 19'd6;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            sector1_reg <= hsvrgb_pkg::sector_t'(h6[18:16]);
            frac1_reg   <= h6[15:0];
            sat1_reg    <= hsv.sat_level;
            val1_reg    <= hsv.val_level;
        end
    end

    // stage 2: s*f, s*(1-f), v*(255-s)
    logic [16:0]         frac_inv;
    logic [24:0]         sfb_full;
    hsvrgb_pkg::sector_t sector2_reg;
    logic [23:0]         sf2_reg;
    logic [23:0]         sfb2_reg;
    logic [15:0]         pv2_reg;
    logic [7:0]          val2_reg;

    assign frac_inv = hsvrgb_pkg::FRAC_ONE - {1'b0, frac1_reg};
    assign sfb_full = {17'd0, sat1_reg} * {8'd0, frac_inv};

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            sector2_reg <= sector1_reg;
            sf2_reg     <= {16'd0, sat1_reg} * {8'd0, frac1_reg};
            sfb2_reg    <= sfb_full[23:0];
            pv2_reg     <= {8'd0, val1_reg} * {8'd0, hsvrgb_pkg::FULL_SCALE - sat1_reg};
            val2_reg    <= val1_reg;
        end
    end

    // stage 3: v * numerator for q and t
    logic [23:0]         num_q;
    logic [23:0]         num_t;
    hsvrgb_pkg::sector_t sector3_reg;
    logic [31:0]         xq3_reg;
    logic [31:0]         xt3_reg;
    logic [15:0]         pv3_reg;
    logic [7:0]          val3_reg;

    assign num_q = hsvrgb_pkg::FULL_SCALE_FRAC - sf2_reg;
    assign num_t = hsvrgb_pkg::FULL_SCALE_FRAC - sfb2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            sector3_reg <= sector2_reg;
            xq3_reg     <= {24'd0, val2_reg} * {8'd0, num_q};
            xt3_reg     <= {24'd0, val2_reg} * {8'd0, num_t};
            pv3_reg     <= pv2_reg;
            val3_reg    <= val2_reg;
        end
    end

    // stage 4: drop the 2^16 factor, then divide by 255 via reciprocal
    hsvrgb_pkg::sector_t sector4_reg;
    logic [31:0]         mq4_reg;
    logic [31:0]         mt4_reg;
    logic [31:0]         mp4_reg;
    logic [7:0]          val4_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            sector4_reg <= sector3_reg;
            mq4_reg     <= {16'd0, xq3_reg[31:16]} * {16'd0, hsvrgb_pkg::RECIP_255};
            mt4_reg     <= {16'd0, xt3_reg[31:16]} * {16'd0, hsvrgb_pkg::RECIP_255};
            mp4_reg     <= {16'd0, pv3_reg} * {16'd0, hsvrgb_pkg::RECIP_255};
            val4_reg    <= val3_reg;
        end
    end

    // stage 5: sector mux into the output register
    localparam int QLO = hsvrgb_pkg::RECIP_SHIFT;

    logic [7:0] term_q;
    logic [7:0] term_t;
    logic [7:0] term_p;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    assign term_q = mq4_reg[QLO+7:QLO];
    assign term_t = mt4_reg[QLO+7:QLO];
    assign term_p = mp4_reg[QLO+7:QLO];

    always_comb
    begin
        unique case (sector4_reg)
            hsvrgb_pkg::SEC_RED_YELLOW:
            begin
                red_next = val4_reg; green_next = term_t; blue_next = term_p;
            end
            hsvrgb_pkg::SEC_YELLOW_GREEN:
            begin
                red_next = term_q; green_next = val4_reg; blue_next = term_p;
            end
            hsvrgb_pkg::SEC_GREEN_CYAN:
            begin
                red_next = term_p; green_next = val4_reg; blue_next = term_t;
            end
            hsvrgb_pkg::SEC_CYAN_BLUE:
            begin
                red_next = term_p; green_next = term_q; blue_next = val4_reg;
            end
            hsvrgb_pkg::SEC_BLUE_MAGENTA:
            begin
                red_next = term_t; green_next = term_p; blue_next = val4_reg;
            end
            default:
            begin
                red_next = val4_reg; green_next = term_p; blue_next = term_q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

    `HSVRGB_ASSERT_NOW(a_sector_range, clk, rst_n, ctl.valid[0],
        sector1_reg <= hsvrgb_pkg::SEC_MAGENTA_RED)
    `HSVRGB_ASSERT_NOW(a_terms_below_v, clk, rst_n, ctl.valid[3],
        term_q <= val4_reg && term_t <= val4_reg && term_p <= val4_reg)
    `HSVRGB_ASSERT_NEXT(a_stage3_holds, clk, rst_n, ctl.valid[2] && !ctl.load[2],
        ctl.valid[2] && $stable(xq3_reg) && $stable(xt3_reg))

endmodule
